### rtl/core/smoothed_rms_level_meter_macros.svh
// Assertion macros shared by the level meter RTL.
`ifndef SMOOTHED_RMS_LEVEL_METER_MACROS_SVH
`define SMOOTHED_RMS_LEVEL_METER_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define SRLM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("srlm: same-cycle check failed");

// Check that cons holds in the cycle after ante.
`define SRLM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("srlm: next-cycle check failed");

`endif

### rtl/core/srlm_pkg.sv
// Types, constants and codes of the smoothed RMS level meter.
package srlm_pkg;

    localparam int MAX_FRAMES  = 256;
    localparam int SAMPLE_W    = 16;
    localparam int LEVEL_W     = 16;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 2;
    localparam int SUM_W       = 40;
    localparam int SMOOTH_W    = 24;
    localparam int DIVIDEND_W  = 40;
    localparam int DIVISOR_W   = 16;

    localparam logic [SMOOTH_W-1:0]   SMOOTH_MAX       = 24'h80_0000;
    localparam logic [LEVEL_W-1:0]    RMS_MAX          = 16'd32768;
    localparam logic [CFG_DATA_W-1:0] WEIGHT_RESET     = 16'd4588;
    localparam logic [CFG_DATA_W-1:0] FULL_SCALE_RESET = 16'd5571;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_SMOOTHING_WEIGHT = 2'd0,
        REG_FULL_SCALE_LEVEL = 2'd1
    } t_cfg_reg;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ_L,
        ST_SQ_R,
        ST_ADD_R,
        ST_MEAN_GO,
        ST_DIV_MEAN,
        ST_SQRT,
        ST_MUL_OLD,
        ST_MUL_NEW,
        ST_SMOOTH,
        ST_SCALE_GO,
        ST_DIV_SCALE,
        ST_EMIT
    } t_state;

    typedef logic signed [SAMPLE_W-1:0] t_sample;

    typedef struct packed {
        logic [LEVEL_W-1:0] block_rms;
        logic [LEVEL_W-1:0] smoothed_level;
        logic [LEVEL_W-1:0] scaled_level;
        logic               overflowed;
    } t_result;

endpackage

### rtl/core/srlm_if.sv
// Stream interfaces for frame input and level result output.
interface srlm_in_if;
    logic                valid;
    logic                ready;
    srlm_pkg::t_sample   left_sample;
    srlm_pkg::t_sample   right_sample;
    logic                end_of_block;

    modport source (output valid, output left_sample, output right_sample,
                    output end_of_block, input ready);
    modport sink (input valid, input left_sample, input right_sample,
                  input end_of_block, output ready);
endinterface

interface srlm_out_if;
    logic                          valid;
    logic                          ready;
    logic [srlm_pkg::LEVEL_W-1:0]  block_rms;
    logic [srlm_pkg::LEVEL_W-1:0]  smoothed_level;
    logic [srlm_pkg::LEVEL_W-1:0]  scaled_level;
    logic                          overflowed;

    modport source (output valid, output block_rms, output smoothed_level,
                    output scaled_level, output overflowed, input ready);
    modport sink (input valid, input block_rms, input smoothed_level,
                  input scaled_level, input overflowed, output ready);
endinterface

### rtl/core/srlm_divider.sv
// Iterative restoring divider, one quotient bit per cycle.
module srlm_divider #(
    parameter int DIVIDEND_W = srlm_pkg::DIVIDEND_W,
    parameter int DIVISOR_W  = srlm_pkg::DIVISOR_W
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [DIVIDEND_W-1:0] i_dividend,
    input  logic [DIVISOR_W-1:0]  i_divisor,
    output logic                  o_done,
    output logic [DIVIDEND_W-1:0] o_quotient
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic                  r_busy;
    logic                  r_done;
    logic [CNT_W-1:0]      r_cnt;
    logic [DIVISOR_W-1:0]  r_rem;
    logic [DIVISOR_W-1:0]  r_dvr;
    logic [DIVIDEND_W-1:0] r_quo;

    logic [DIVISOR_W:0]    rem_sh;
    logic [DIVISOR_W+1:0]  diff;
    logic                  fits;

    // Shift in the next dividend bit and trial-subtract the divisor
    always_comb begin
        rem_sh = {r_rem, r_quo[DIVIDEND_W-1]};
        diff   = {1'b0, rem_sh} - {2'b00, r_dvr};
        fits   = !diff[DIVISOR_W+1];
    end

    // Count the steps and flag the last one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIVIDEND_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Load operands, then shift quotient bits in where dividend bits leave
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvr <= i_divisor;
        end else if (r_busy) begin
            r_rem <= fits ? diff[DIVISOR_W-1:0] : rem_sh[DIVISOR_W-1:0];
            r_quo <= {r_quo[DIVIDEND_W-2:0], fits};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

### rtl/core/smoothed_rms_level_meter.sv
// Smoothed RMS level meter: square-sum, mean, root, smoothing and scaling.
// An ordinary frame passes SQ_L, SQ_R and ADD_R between acceptance and ready again.
// An end-of-block frame is followed by two 40-step passes of the shared divider and a
// 16-step square root before the result beat, and ready returns once the beat is loaded.
// The result sits in an output register; the next frame is taken while it waits.
// Reset (synchronous, active low) clears sums, count, smoothed level; registers default.
`include "smoothed_rms_level_meter_macros.svh"

module smoothed_rms_level_meter #(
    parameter int MAX_FRAMES = srlm_pkg::MAX_FRAMES
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    srlm_in_if.sink                            i_frame,
    srlm_out_if.source                         o_result,
    input  logic                               i_cfg_we,
    input  logic [srlm_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [srlm_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int CNT_W = $clog2(MAX_FRAMES + 1);
    localparam int DVD_W = srlm_pkg::DIVIDEND_W;
    localparam int DVR_W = srlm_pkg::DIVISOR_W;
    localparam int SUM_W = srlm_pkg::SUM_W;
    localparam int SM_W  = srlm_pkg::SMOOTH_W;
    localparam int LVL_W = srlm_pkg::LEVEL_W;

    // Control and state registers
    srlm_pkg::t_state              r_state;
    srlm_pkg::t_state              n_state;
    logic [SUM_W-1:0]              r_sum;
    logic [CNT_W-1:0]              r_count;
    logic                          r_ovf;
    logic [SM_W-1:0]               r_smooth;
    logic [srlm_pkg::CFG_DATA_W-1:0] r_weight;
    logic [srlm_pkg::CFG_DATA_W-1:0] r_full_scale;
    logic                          r_out_valid;
    logic [3:0]                    r_iter;
    logic                          r_eob;

    // Payload registers
    srlm_pkg::t_sample             r_l;
    srlm_pkg::t_sample             r_r;
    logic [40:0]                   r_prod;
    logic [40:0]                   r_acc;
    logic [31:0]                   r_x;
    logic [18:0]                   r_rem;
    logic [15:0]                   r_root;
    logic [LVL_W-1:0]              r_rms;
    logic [LVL_W-1:0]              r_scaled;
    srlm_pkg::t_result             r_out;

    // Combinational signals
    logic                          in_acc;
    logic                          count_full;
    logic                          load_out;
    logic                          div_start;
    logic [DVD_W-1:0]              div_dividend;
    logic [DVR_W-1:0]              div_divisor;
    logic                          div_done;
    logic [DVD_W-1:0]              div_q;
    logic [23:0]                   mul_a;
    logic [16:0]                   mul_b;
    logic [40:0]                   mul_p;
    logic [16:0]                   abs_l;
    logic [16:0]                   abs_r;
    logic [SUM_W:0]                sum_raw;
    logic [SUM_W-1:0]              sum_sat;
    logic [18:0]                   rem4;
    logic [18:0]                   trial;
    logic                          root_bit;
    logic [18:0]                   n_rem;
    logic [15:0]                   n_root;
    logic [41:0]                   smooth_sum;
    logic [25:0]                   smooth_new;
    logic [24:0]                   level_sum;

    assign in_acc     = i_frame.valid && i_frame.ready;
    assign count_full = (r_count >= CNT_W'(MAX_FRAMES));

    // Shared divider for the mean square and the full-scale ratio
    srlm_divider #(
        .DIVIDEND_W (DVD_W),
        .DIVISOR_W  (DVR_W)
    ) u_divider (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    // Shared multiplier
    assign mul_p = mul_a * mul_b;

    // Magnitudes of the held samples
    assign abs_l = r_l[15] ? (17'd0 - {r_l[15], r_l}) : {1'b0, r_l};
    assign abs_r = r_r[15] ? (17'd0 - {r_r[15], r_r}) : {1'b0, r_r};

    // Saturating add of the last square into the running sum
    always_comb begin
        sum_raw = {1'b0, r_sum} + r_prod;
        sum_sat = sum_raw[SUM_W] ? '1 : sum_raw[SUM_W-1:0];
    end

    // One step of the digit-by-digit square root
    always_comb begin
        rem4     = {r_rem[16:0], r_x[31:30]};
        trial    = {1'b0, r_root, 2'b01};
        root_bit = (rem4 >= trial);
        n_rem    = root_bit ? (rem4 - trial) : rem4;
        n_root   = {r_root[14:0], root_bit};
    end

    // Smoothing sum with rounding, and output level rounding
    always_comb begin
        smooth_sum = {1'b0, r_acc} + {1'b0, r_prod} + 42'd32768;
        smooth_new = smooth_sum[41:16];
        level_sum  = {1'b0, r_smooth} + 25'd128;
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            srlm_pkg::ST_IDLE: begin
                if (in_acc) begin
                    if (!count_full) begin
                        n_state = srlm_pkg::ST_SQ_L;
                    end else if (i_frame.end_of_block) begin
                        n_state = srlm_pkg::ST_MEAN_GO;
                    end
                end
            end
            srlm_pkg::ST_SQ_L:      n_state = srlm_pkg::ST_SQ_R;
            srlm_pkg::ST_SQ_R:      n_state = srlm_pkg::ST_ADD_R;
            srlm_pkg::ST_ADD_R: begin
                n_state = r_eob ? srlm_pkg::ST_MEAN_GO : srlm_pkg::ST_IDLE;
            end
            srlm_pkg::ST_MEAN_GO:   n_state = srlm_pkg::ST_DIV_MEAN;
            srlm_pkg::ST_DIV_MEAN: begin
                if (div_done) begin
                    n_state = srlm_pkg::ST_SQRT;
                end
            end
            srlm_pkg::ST_SQRT: begin
                if (r_iter == 4'd0) begin
                    n_state = srlm_pkg::ST_MUL_OLD;
                end
            end
            srlm_pkg::ST_MUL_OLD:   n_state = srlm_pkg::ST_MUL_NEW;
            srlm_pkg::ST_MUL_NEW:   n_state = srlm_pkg::ST_SMOOTH;
            srlm_pkg::ST_SMOOTH:    n_state = srlm_pkg::ST_SCALE_GO;
            srlm_pkg::ST_SCALE_GO:  n_state = srlm_pkg::ST_DIV_SCALE;
            srlm_pkg::ST_DIV_SCALE: begin
                if (div_done) begin
                    n_state = srlm_pkg::ST_EMIT;
                end
            end
            srlm_pkg::ST_EMIT: begin
                if (load_out) begin
                    n_state = srlm_pkg::ST_IDLE;
                end
            end
            default:                n_state = srlm_pkg::ST_IDLE;
        endcase
    end

    // Sequencer outputs: handshake, divider start, multiplier operands
    always_comb begin
        i_frame.ready = 1'b0;
        load_out      = 1'b0;
        div_start     = 1'b0;
        div_dividend  = '0;
        div_divisor   = '0;
        mul_a         = '0;
        mul_b         = '0;
        unique case (r_state)
            srlm_pkg::ST_IDLE: begin
                i_frame.ready = 1'b1;
            end
            srlm_pkg::ST_SQ_L: begin
                mul_a = {7'd0, abs_l};
                mul_b = abs_l;
            end
            srlm_pkg::ST_SQ_R: begin
                mul_a = {7'd0, abs_r};
                mul_b = abs_r;
            end
            srlm_pkg::ST_MEAN_GO: begin
                div_start    = 1'b1;
                div_dividend = DVD_W'(r_sum);
                div_divisor  = DVR_W'({r_count, 1'b0});
            end
            srlm_pkg::ST_MUL_OLD: begin
                mul_a = r_smooth;
                mul_b = 17'h1_0000 - {1'b0, r_weight};
            end
            srlm_pkg::ST_MUL_NEW: begin
                mul_a = {r_rms, 8'd0};
                mul_b = {1'b0, r_weight};
            end
            srlm_pkg::ST_SCALE_GO: begin
                div_start    = 1'b1;
                div_dividend = DVD_W'({r_smooth, 8'd0});
                div_divisor  = r_full_scale;
            end
            srlm_pkg::ST_EMIT: begin
                load_out = !r_out_valid || o_result.ready;
            end
            default: begin
            end
        endcase
    end

    // Control state, accumulators and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= srlm_pkg::ST_IDLE;
            r_sum        <= '0;
            r_count      <= '0;
            r_ovf        <= 1'b0;
            r_smooth     <= '0;
            r_weight     <= srlm_pkg::WEIGHT_RESET;
            r_full_scale <= srlm_pkg::FULL_SCALE_RESET;
            r_out_valid  <= 1'b0;
            r_iter       <= '0;
            r_eob        <= 1'b0;
        end else begin
            r_state <= n_state;

            // Write configuration registers
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    srlm_pkg::REG_SMOOTHING_WEIGHT: r_weight     <= i_cfg_data;
                    srlm_pkg::REG_FULL_SCALE_LEVEL: r_full_scale <= i_cfg_data;
                    default: begin
                    end
                endcase
            end

            unique case (r_state)
                srlm_pkg::ST_IDLE: begin
                    if (in_acc) begin
                        r_eob <= i_frame.end_of_block;
                        if (count_full) begin
                            r_ovf <= 1'b1;
                        end
                    end
                end
                srlm_pkg::ST_SQ_R: begin
                    r_sum <= sum_sat;
                end
                srlm_pkg::ST_ADD_R: begin
                    r_sum   <= sum_sat;
                    r_count <= r_count + 1'b1;
                end
                srlm_pkg::ST_DIV_MEAN: begin
                    if (div_done) begin
                        r_iter <= 4'd15;
                    end
                end
                srlm_pkg::ST_SQRT: begin
                    r_iter <= r_iter - 1'b1;
                end
                srlm_pkg::ST_SMOOTH: begin
                    if (smooth_new > 26'(srlm_pkg::SMOOTH_MAX)) begin
                        r_smooth <= srlm_pkg::SMOOTH_MAX;
                    end else begin
                        r_smooth <= smooth_new[SM_W-1:0];
                    end
                end
                srlm_pkg::ST_EMIT: begin
                    if (load_out) begin
                        r_sum   <= '0;
                        r_count <= '0;
                        r_ovf   <= 1'b0;
                    end
                end
                default: begin
                end
            endcase

            // Hold the result beat until the sink takes it
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_l <= i_frame.left_sample;
            r_r <= i_frame.right_sample;
        end

        unique case (r_state) inside
            srlm_pkg::ST_SQ_L, srlm_pkg::ST_SQ_R, srlm_pkg::ST_MUL_OLD: begin
                r_prod <= mul_p;
            end
            srlm_pkg::ST_MUL_NEW: begin
                r_acc  <= r_prod;
                r_prod <= mul_p;
            end
            srlm_pkg::ST_DIV_MEAN: begin
                if (div_done) begin
                    r_x    <= (r_count == '0) ? 32'd0 : div_q[31:0];
                    r_rem  <= '0;
                    r_root <= '0;
                end
            end
            srlm_pkg::ST_SQRT: begin
                r_x    <= {r_x[29:0], 2'b00};
                r_rem  <= n_rem;
                r_root <= n_root;
                if (r_iter == 4'd0) begin
                    r_rms <= (n_root > srlm_pkg::RMS_MAX) ? srlm_pkg::RMS_MAX : n_root;
                end
            end
            srlm_pkg::ST_DIV_SCALE: begin
                if (div_done) begin
                    if ((r_full_scale == '0) || (|div_q[DVD_W-1:LVL_W])) begin
                        r_scaled <= '1;
                    end else begin
                        r_scaled <= div_q[LVL_W-1:0];
                    end
                end
            end
            default: begin
            end
        endcase

        // Capture the result beat
        if (load_out) begin
            r_out.block_rms      <= r_rms;
            r_out.smoothed_level <= level_sum[23:8];
            r_out.scaled_level   <= r_scaled;
            r_out.overflowed     <= r_ovf;
        end
    end

    assign o_result.valid          = r_out_valid;
    assign o_result.block_rms      = r_out.block_rms;
    assign o_result.smoothed_level = r_out.smoothed_level;
    assign o_result.scaled_level   = r_out.scaled_level;
    assign o_result.overflowed     = r_out.overflowed;

    // Assertions
    `SRLM_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(MAX_FRAMES))
    `SRLM_ASSERT_NOW(a_smooth_bound, i_clk, i_rst_n, 1'b1, r_smooth <= srlm_pkg::SMOOTH_MAX)
    `SRLM_ASSERT_NOW(a_div_done_state, i_clk, i_rst_n, div_done, r_state == srlm_pkg::ST_DIV_MEAN || r_state == srlm_pkg::ST_DIV_SCALE)
    `SRLM_ASSERT_NEXT(a_emit_clears, i_clk, i_rst_n, load_out, r_count == '0 && !r_ovf && r_sum == '0)
    `SRLM_ASSERT_NOW(a_rms_bound, i_clk, i_rst_n, r_out_valid, r_out.block_rms <= srlm_pkg::RMS_MAX)

endmodule
